### sv/ffra_pkg.sv
package ffra_pkg;

   // default grid size in 4x4 texel blocks
   localparam int FFRA_GRID_W = 64;
   localparam int FFRA_GRID_H = 64;

   // field widths
   localparam int POS_W  = 6;
   localparam int SIZE_W = 7;
   localparam int TAG_W  = 16;

   // operation codes
   localparam logic OP_FIND = 1'b0;
   localparam logic OP_FILL = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_FREAD,
      ST_FDRAIN,
      ST_FSCAN,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_DONE
   } state_type;

   // what the result registers take
   typedef enum logic [1:0] {
      RES_ORIGIN,
      RES_MISS,
      RES_HIT
   } res_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         row_start;
      logic         next_row;
      logic         rd_issue;
      logic         scan;
      logic         fill_rd;
      logic         fill_wr;
      logic         clr_wr;
      logic         res_set;
      res_kind_type res_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_fill;
      logic fill_empty;
      logic wh_zero;
      logic oversize;
      logic read_last;
      logic scan_hit;
      logic scan_end;
      logic rows_end;
      logic fill_last;
      logic clear_last;
   } status_type;

endpackage

### sv/ffra_dpath.sv
module ffra_dpath #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffra_pkg::cmd_type     cmd,
   output ffra_pkg::status_type  status,
   input  logic                  req_operation,
   input  logic [5:0]            req_rect_x,
   input  logic [5:0]            req_rect_y,
   input  logic [6:0]            req_rect_width,
   input  logic [6:0]            req_rect_height,
   input  logic [15:0]           req_owner_tag,
   output logic                  rsp_found,
   output logic [5:0]            rsp_pos_x,
   output logic [5:0]            rsp_pos_y
);
   import ffra_pkg::*;

   localparam int AW  = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int CIW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int RW  = $clog2(GRID_H + 256) + 1;
   localparam int MXW = $clog2(GRID_W + 256) + 1;
   localparam int PW  = CIW + 8;

   // row bitmap: one bit per cell, set when the cell holds a nonzero tag
   logic [GRID_W-1:0] mem [GRID_H];
   logic [GRID_W-1:0] rd_data_ff;

   // request copy
   logic              op_ff, op_in;
   logic [5:0]        y_ff, y_in;
   logic [6:0]        w_ff, w_in;
   logic [6:0]        h_ff, h_in;
   logic              tag_nz_ff, tag_nz_in;
   logic [GRID_W-1:0] mask_ff, mask_in;

   // scan state
   logic [RW-1:0]     row_ff, row_in;
   logic [6:0]        k_ff, k_in;
   logic              pend_ff, pend_in;
   logic [GRID_W-1:0] acc_ff, acc_in;
   logic [CIW-1:0]    col_ff, col_in;
   logic [6:0]        span_ff, span_in;
   logic [7:0]        span_next;

   // result
   logic              found_ff, found_in;
   logic [5:0]        pos_x_ff, pos_x_in;
   logic [5:0]        pos_y_ff, pos_y_in;

   logic [RW-1:0]     rd_sum;
   logic [AW-1:0]     raddr;
   logic              re;
   logic              we;
   logic [GRID_W-1:0] wdata;
   logic [PW-1:0]     px;

   // fill column mask, one compare pair per column
   always_comb begin
      for (int i = 0; i < GRID_W; i++) begin
         mask_in[i] = (MXW'(i) >= MXW'(req_rect_x)) &&
                      (MXW'(i) < (MXW'(req_rect_x) + MXW'(req_rect_width)));
      end
   end

   // memory ports
   assign rd_sum = row_ff + RW'(k_ff);
   assign raddr  = cmd.fill_rd ? row_ff[AW-1:0] : rd_sum[AW-1:0];
   assign re     = cmd.rd_issue | cmd.fill_rd;
   assign we     = cmd.fill_wr | cmd.clr_wr;
   assign wdata  = cmd.clr_wr ? '0 :
                   ((rd_data_ff & ~mask_ff) | (tag_nz_ff ? mask_ff : '0));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[row_ff[AW-1:0]] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   // run of free columns
   assign span_next = acc_ff[0] ? 8'd0 : (8'(span_ff) + 8'd1);
   assign px        = PW'(col_ff) + PW'(1) - PW'(w_ff);

   // status
   always_comb begin
      status.is_fill    = (op_ff == OP_FILL);
      status.fill_empty = (h_ff == 7'd0) || (RW'(y_ff) >= RW'(GRID_H));
      status.wh_zero    = (w_ff == 7'd0) || (h_ff == 7'd0);
      status.oversize   = (MXW'(w_ff) > MXW'(GRID_W)) || (RW'(h_ff) > RW'(GRID_H));
      status.read_last  = ((8'(k_ff) + 8'd1) == 8'(h_ff));
      status.scan_hit   = (span_next >= 8'(w_ff));
      status.scan_end   = (col_ff == CIW'(GRID_W - 1));
      status.rows_end   = ((row_ff + RW'(1) + RW'(h_ff)) > RW'(GRID_H));
      status.fill_last  = ((row_ff + RW'(1)) >= (RW'(y_ff) + RW'(h_ff))) ||
                          ((row_ff + RW'(1)) >= RW'(GRID_H));
      status.clear_last = (row_ff == RW'(GRID_H - 1));
   end

   // next values
   always_comb begin
      op_in     = op_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      tag_nz_in = tag_nz_ff;
      row_in    = row_ff;
      k_in      = k_ff;
      pend_in   = cmd.rd_issue;
      acc_in    = acc_ff;
      col_in    = col_ff;
      span_in   = span_ff;
      found_in  = found_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;

      // latch request
      if (cmd.load) begin
         op_in     = req_operation;
         y_in      = req_rect_y;
         w_in      = req_rect_width;
         h_in      = req_rect_height;
         tag_nz_in = (req_owner_tag != '0);
         row_in    = (req_operation == OP_FILL) ? RW'(req_rect_y) : '0;
      end

      // row walk
      if (cmd.clr_wr || cmd.fill_wr || cmd.next_row) begin
         row_in = row_ff + RW'(1);
      end

      // column mask of one origin row
      if (cmd.row_start) begin
         acc_in  = '0;
         k_in    = '0;
         col_in  = '0;
         span_in = '0;
      end else begin
         if (cmd.rd_issue) begin
            k_in = k_ff + 7'd1;
         end
         if (pend_ff) begin
            acc_in = acc_ff | rd_data_ff;
         end else if (cmd.scan) begin
            acc_in  = acc_ff >> 1;
            col_in  = col_ff + CIW'(1);
            span_in = span_next[6:0];
         end
      end

      // result
      if (cmd.res_set) begin
         case (cmd.res_kind)
            RES_HIT: begin
               found_in = 1'b1;
               pos_x_in = px[5:0];
               pos_y_in = row_ff[5:0];
            end
            RES_MISS: begin
               found_in = 1'b0;
               pos_x_in = '0;
               pos_y_in = '0;
            end
            default: begin
               found_in = 1'b1;
               pos_x_in = '0;
               pos_y_in = '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      y_ff      <= y_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      tag_nz_ff <= tag_nz_in;
      if (cmd.load) begin
         mask_ff <= mask_in;
      end
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      col_ff    <= col_in;
      span_ff   <= span_in;
      found_ff  <= found_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
   end

   assign rsp_found = found_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;

endmodule

### sv/ffra_ctrl.sv
module ffra_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output ffra_pkg::cmd_type     cmd,
   input  ffra_pkg::status_type  status
);
   import ffra_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.is_fill) begin
               state_in = status.fill_empty ? ST_DONE : ST_FILL_RD;
            end else if (status.wh_zero || status.oversize) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FREAD;
            end
         end
         ST_FREAD: begin
            if (status.read_last) state_in = ST_FDRAIN;
         end
         ST_FDRAIN: begin
            state_in = ST_FSCAN;
         end
         ST_FSCAN: begin
            if (status.scan_hit) begin
               state_in = ST_DONE;
            end else if (status.scan_end) begin
               state_in = status.rows_end ? ST_DONE : ST_FREAD;
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            state_in = status.fill_last ? ST_DONE : ST_FILL_RD;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.res_kind = RES_ORIGIN;
      busy         = (state_ff != ST_IDLE);
      rsp_strobe   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_CHECK: begin
            if (status.is_fill) begin
               cmd.res_set = status.fill_empty;
            end else if (status.wh_zero) begin
               cmd.res_set = 1'b1;
            end else if (status.oversize) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = RES_MISS;
            end else begin
               cmd.row_start = 1'b1;
            end
         end
         ST_FREAD: begin
            cmd.rd_issue = 1'b1;
         end
         ST_FSCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = RES_HIT;
            end else if (status.scan_end) begin
               if (status.rows_end) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_kind = RES_MISS;
               end else begin
                  cmd.next_row  = 1'b1;
                  cmd.row_start = 1'b1;
               end
            end
         end
         ST_FILL_RD: begin
            cmd.fill_rd = 1'b1;
         end
         ST_FILL_WR: begin
            cmd.fill_wr = 1'b1;
            cmd.res_set = status.fill_last;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            cmd.res_kind = RES_ORIGIN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/atlas_first_fit_rect_allocator_core.sv
// First-fit rectangle allocator for a glyph atlas grid of GRID_W x GRID_H
// cells (one per 4x4 texel block). The core keeps one occupied bit per cell
// in a row-wide memory. After reset it clears the memory one row at a time
// with busy high. A request transfers when start is high and busy is low; its
// result appears for exactly one cycle with rsp_strobe and cannot be held
// off, so the receiver must take it on that cycle. A fill does a
// read-modify-write of each covered memory row, a read state followed by a
// write state per row. A find with rect_width or rect_height zero, or too
// large for the grid, ends without reading the memory. Otherwise each
// candidate origin row first gathers the occupancy of the rows it would
// span (one memory read per cycle) and then scans up to GRID_W columns one
// per cycle; a find stops at the first fit. pos_x and pos_y carry the low
// six bits of the origin.
module atlas_first_fit_rect_allocator_core #(
   parameter int GRID_W = ffra_pkg::FFRA_GRID_W,
   parameter int GRID_H = ffra_pkg::FFRA_GRID_H
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [5:0]  req_rect_x,
   input  logic [5:0]  req_rect_y,
   input  logic [6:0]  req_rect_width,
   input  logic [6:0]  req_rect_height,
   input  logic [15:0] req_owner_tag,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [5:0]  rsp_pos_x,
   output logic [5:0]  rsp_pos_y
);
   import ffra_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // occupancy memory, scan and result registers
   ffra_dpath #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_owner_tag   (req_owner_tag),
      .rsp_found       (rsp_found),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

endmodule
